@@ src/tdlcd_pkg.sv @@
// Package with the codes and segment tables of the two-digit segment LCD driver.
`default_nettype none
package tdlcd_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned DWELL_W = 14;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned FRAME_W = 3;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [VALUE_W-1:0] C_CODE_OK      = 16'd111;
    localparam logic [VALUE_W-1:0] C_CODE_CANCEL  = 16'd222;
    localparam logic [VALUE_W-1:0] C_VALUE_TEN    = 16'd10;
    localparam logic [VALUE_W-1:0] C_VALUE_HUNDRED = 16'd100;
    localparam logic [DWELL_W-1:0] C_DWELL_RESET  = 14'd15000;
    localparam logic [FRAME_W-1:0] C_FRAME_LAST   = 3'd5;
    localparam logic [SEG_W-1:0]   C_SEG_BLANK    = 8'h00;
    localparam logic [SEG_W-1:0]   C_SEG_ALL      = 8'hFF;

    typedef logic [SEG_W-1:0] t_seg;

    function automatic t_seg f_digit_seg(input logic [3:0] digit);
        t_seg seg;
        case (digit)
            4'd0: seg = 8'b0111_0111;
            4'd1: seg = 8'b0001_0001;
            4'd2: seg = 8'b0110_1011;
            4'd3: seg = 8'b0011_1011;
            4'd4: seg = 8'b0001_1101;
            4'd5: seg = 8'b0011_1110;
            4'd6: seg = 8'b0111_1110;
            4'd7: seg = 8'b0001_0011;
            4'd8: seg = 8'b0111_1111;
            4'd9: seg = 8'b0011_1111;
            default: seg = C_SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic t_seg f_anim_seg(input logic [FRAME_W-1:0] frame);
        t_seg seg;
        case (frame)
            3'd0: seg = 8'h76;
            3'd1: seg = 8'h67;
            3'd2: seg = 8'h57;
            3'd3: seg = 8'h37;
            3'd4: seg = 8'h73;
            3'd5: seg = 8'h75;
            default: seg = 8'h76;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

@@ src/two_digit_segment_lcd_driver.sv @@
// Two-digit seven-segment LCD driver with AC backplane drive, top level.
// One refresh transaction is accepted per clock cycle while the output is not stalled;
// its result passes from the input register through the decode to the result register,
// and a result that waits holds the result register and a filled input register.
// Values 10 to 99 show ones on digit one and tens on digit two, values
// 1 to 9 and above 100 use digit one only, 0 and 100 blank both digits. Value 111
// plays a six-frame animation held for animation_dwell refreshes per frame, 222
// blanks digit one, other values above 100 light all of digit one. With drive phase
// 0 the segment bytes are inverted and the backplane is high.
`default_nettype none
module two_digit_segment_lcd_driver (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [tdlcd_pkg::DWELL_W-1:0]        i_cfg_wr_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [15:0] display_value, [16] drive_phase, [23:17] zero.
    input  wire logic [tdlcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] digit_one_segments, [15:8] digit_two_segments, [16] backplane_level,
    // [23:17] zero.
    output logic [tdlcd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import tdlcd_pkg::*;

    logic               r_dwell;
    logic [DWELL_W-1:0] r_dwell_val;
    logic [FRAME_W-1:0] r_frame;
    logic [DWELL_W-1:0] r_dwell_cnt;
    logic               r_s1_valid;
    logic [VALUE_W-1:0] r_value;
    logic               r_phase;
    logic               r_out_valid;
    logic [SEG_W-1:0]   r_d1;
    logic [SEG_W-1:0]   r_d2;
    logic               r_bp;

    logic               w_in_go;
    logic               w_s1_go;
    logic               w_is_ok;
    logic               w_anim_step;
    logic [6:0]         w_low;
    logic [14:0]        w_prod;
    logic [3:0]         w_tens;
    logic [6:0]         w_tens_x10;
    logic [6:0]         w_ones_full;
    logic [DWELL_W-1:0] w_cnt_inc;
    logic               w_wrap;
    t_seg               n_d1;
    t_seg               n_d2;
    logic [DWELL_W-1:0] n_dwell_cnt;
    logic [FRAME_W-1:0] n_frame;

    assign w_s1_go       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_go;
    assign w_in_go       = s_axis_tvalid && s_axis_tready;

    assign w_low       = r_value[6:0];
    assign w_prod      = 15'(w_low) * 15'd205;
    assign w_tens      = w_prod[14:11];
    assign w_tens_x10  = {w_tens, 3'b000} + {2'b00, w_tens, 1'b0};
    assign w_ones_full = w_low - w_tens_x10;

    assign w_is_ok     = (r_value == C_CODE_OK);
    assign w_anim_step = w_s1_go && w_is_ok;
    assign w_cnt_inc   = r_dwell_cnt + 1'b1;
    assign w_wrap      = (w_cnt_inc >= r_dwell_val);

    always_comb begin
        n_d1 = C_SEG_BLANK;
        n_d2 = C_SEG_BLANK;
        if (r_value >= C_VALUE_TEN && r_value < C_VALUE_HUNDRED) begin
            n_d1 = f_digit_seg(w_ones_full[3:0]);
            n_d2 = f_digit_seg(w_tens);
        end else if (r_value != '0 && r_value < C_VALUE_TEN) begin
            n_d1 = f_digit_seg(r_value[3:0]);
        end else if (r_value > C_VALUE_HUNDRED) begin
            if (w_is_ok) begin
                n_d1 = f_anim_seg(r_frame);
            end else if (r_value == C_CODE_CANCEL) begin
                n_d1 = C_SEG_BLANK;
            end else begin
                n_d1 = C_SEG_ALL;
            end
        end
        if (!r_phase) begin
            n_d1 = ~n_d1;
            n_d2 = ~n_d2;
        end
    end

    always_comb begin
        n_dwell_cnt = r_dwell_cnt;
        n_frame     = r_frame;
        if (w_anim_step) begin
            if (w_wrap) begin
                n_dwell_cnt = '0;
                n_frame     = (r_frame >= C_FRAME_LAST) ? '0 : r_frame + 1'b1;
            end else begin
                n_dwell_cnt = w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell     <= 1'b0;
            r_dwell_val <= C_DWELL_RESET;
            r_frame     <= '0;
            r_dwell_cnt <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dwell     <= i_cfg_wr_en;
            if (i_cfg_wr_en) begin
                r_dwell_val <= i_cfg_wr_data;
            end
            r_frame     <= n_frame;
            r_dwell_cnt <= n_dwell_cnt;
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_value <= s_axis_tdata[VALUE_W-1:0];
            r_phase <= s_axis_tdata[VALUE_W];
        end
        if (w_s1_go) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            r_bp <= !r_phase;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2*SEG_W - 1){1'b0}}, r_bp, r_d2, r_d1};

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= C_FRAME_LAST)
        else $error("Animation frame out of range.");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_anim_step |=> $stable(r_frame) && $stable(r_dwell_cnt))
        else $error("Animation state changed without an ok transaction.");

    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_go |=> r_s1_valid)
        else $error("Accepted transaction was not registered.");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go |=> r_out_valid && (r_bp == !$past(r_phase)))
        else $error("Result register did not take the transaction.");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dwell |-> r_dwell_val == $past(i_cfg_wr_data))
        else $error("Dwell register write lost.");

endmodule
`default_nettype wire
